[rtl/recursive_sine_oscillator_defines.svh]
// ----------------------------------------------------------------------------
// Recursive sine oscillator assertion macros
// Concurrent assertion helpers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef RECURSIVE_SINE_OSCILLATOR_DEFINES_SVH
`define RECURSIVE_SINE_OSCILLATOR_DEFINES_SVH

`ifndef SYNTH
`define RSO_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("recursive_sine_oscillator: assertion failed");
`define RSO_ASSERT_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("recursive_sine_oscillator: forbidden condition");
`else
`define RSO_ASSERT(lbl, prop)
`define RSO_ASSERT_NEVER(lbl, cond)
`endif

`endif

[rtl/rso_pkg.sv]
// ----------------------------------------------------------------------------
// Recursive sine oscillator package
// Shared constants, register indexes and the core-to-output result type.
// ----------------------------------------------------------------------------
package rso_pkg;

	localparam int RSO_VALUE_WIDTH = 32;
	localparam int RSO_COEFF_FRAC = 30;
	localparam logic [14:0] RSO_SAMPLE_SCALE = 15'd32760;

	localparam logic [31:0] RSO_COEFF_RESET = 32'd2142885886;
	localparam logic [31:0] RSO_START_RESET = 32'd70225937;
	localparam logic [15:0] RSO_PERIOD_RESET = 16'd96;

	localparam int RSO_QUEUE_DEPTH = 2;
	localparam int RSO_BUF_DEPTH = 4;

	typedef enum logic [1:0] {
		REG_COEFF_A     = 2'd0,
		REG_START_VALUE = 2'd1,
		REG_PERIOD      = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic               pop;
		logic               valid;
		logic signed [15:0] sample;
	} result_t;

endpackage

[rtl/rso_front.sv]
// ----------------------------------------------------------------------------
// Recursive sine oscillator front end
// Accepts input items, drops idle ticks and queues pending ticks as a count.
// ----------------------------------------------------------------------------
module rso_front (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic sample_tick,
	input  logic pop,
	output logic tick_avail
);
	import rso_pkg::*;

	localparam int CW = $clog2(RSO_QUEUE_DEPTH + 1);

	logic [CW-1:0] pend_q;
	logic          push;

	assign in_ready   = (pend_q < CW'(RSO_QUEUE_DEPTH));
	assign push       = in_valid && in_ready && sample_tick;
	assign tick_avail = (pend_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + CW'(push) - CW'(pop);
		end
	end

endmodule

[rtl/rso_core.sv]
// ----------------------------------------------------------------------------
// Recursive sine oscillator core
// Recursion loop followed by the sample scaling pipeline.
// ----------------------------------------------------------------------------
module rso_core #(
	parameter int VALUE_WIDTH = rso_pkg::RSO_VALUE_WIDTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic signed [31:0] coeff_a,
	input  logic signed [31:0] start_value,
	input  logic [15:0]        period,
	input  logic               tick_avail,
	input  logic               room,
	output rso_pkg::result_t   res
);
	import rso_pkg::*;

	localparam int W    = VALUE_WIDTH;
	localparam int F    = W - 2;
	localparam int LO_W = W / 2;
	localparam int HI_W = W - LO_W;
	localparam int PW   = 32 + W;
	localparam int DW   = W + 4;
	localparam int SH_L = (F >= RSO_COEFF_FRAC) ? F - RSO_COEFF_FRAC : 0;
	localparam int SH_R = (F < RSO_COEFF_FRAC) ? RSO_COEFF_FRAC - F : 0;

	function automatic logic signed [W-1:0] to_fixed(input logic signed [31:0] s);
		logic [31:0]        m;
		logic [31:0]        ms;
		logic signed [W-1:0] r;
		m  = s[31] ? 32'(-s) : s;
		ms = m >> SH_R;
		if (F >= RSO_COEFF_FRAC) begin
			r = W'(s) <<< SH_L;
		end else begin
			r = s[31] ? -$signed(W'(ms)) : $signed(W'(ms));
		end
		return r;
	endfunction

	localparam logic signed [W-1:0] CURR_RESET = to_fixed(RSO_START_RESET);

	logic signed [W-1:0] prev_q;
	logic signed [W-1:0] curr_q;
	logic [15:0]         tick_q;

	logic                v_s1;
	logic                neg_s1;
	logic [32+LO_W-1:0]  pp_lo_s1;
	logic [32+HI_W-1:0]  pp_hi_s1;

	logic                v_s2;
	logic signed [W-1:0] next_s2;

	logic                v_s3;
	logic                neg_s3;
	logic [W+14:0]       prod_s3;

	logic                pop;
	logic [31:0]         am;
	logic [W-1:0]        cm;
	logic [PW-1:0]       prod;
	logic [W+1:0]        q;
	logic signed [DW-1:0] qs;
	logic signed [DW-1:0] diff;
	logic signed [W-1:0] next;
	logic [15:0]         tick_inc;
	logic [W-1:0]        nm;
	logic [16:0]         sm;
	logic signed [15:0]  smp;

	assign pop = tick_avail && !v_s1 && room;
	assign am  = coeff_a[31] ? 32'(-coeff_a) : coeff_a;
	assign cm  = curr_q[W-1] ? W'(-curr_q) : curr_q;

	always_comb begin
		prod = (PW'(pp_hi_s1) << LO_W) + PW'(pp_lo_s1);
		q    = prod[PW-1:RSO_COEFF_FRAC];
		qs   = neg_s1 ? -$signed({2'b00, q}) : $signed({2'b00, q});
		diff = qs - DW'(prev_q);
		if (!diff[DW-1] && (|diff[DW-2:W-1])) begin
			next = {1'b0, {(W-1){1'b1}}};
		end else if (diff[DW-1] && !(&diff[DW-2:W-1])) begin
			next = {1'b1, {(W-1){1'b0}}};
		end else begin
			next = diff[W-1:0];
		end
		tick_inc = tick_q + 16'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			prev_q <= '0;
			curr_q <= CURR_RESET;
			tick_q <= '0;
		end else begin
			v_s1 <= pop;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (v_s1) begin
				if (tick_inc == period) begin
					prev_q <= '0;
					curr_q <= to_fixed(start_value);
					tick_q <= '0;
				end else begin
					prev_q <= curr_q;
					curr_q <= next;
					tick_q <= tick_inc;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			neg_s1   <= coeff_a[31] ^ curr_q[W-1];
			pp_lo_s1 <= (32+LO_W)'(am) * (32+LO_W)'(cm[LO_W-1:0]);
			pp_hi_s1 <= (32+HI_W)'(am) * (32+HI_W)'(cm[W-1:LO_W]);
		end
		if (v_s1) begin
			next_s2 <= next;
		end
		if (v_s2) begin
			neg_s3  <= next_s2[W-1];
			prod_s3 <= (W+15)'(nm) * (W+15)'(RSO_SAMPLE_SCALE);
		end
	end

	assign nm = next_s2[W-1] ? W'(-next_s2) : next_s2;

	always_comb begin
		sm = prod_s3[W+14:F];
		if (!neg_s3) begin
			smp = (sm > 17'd32767) ? 16'sh7fff : $signed(sm[15:0]);
		end else begin
			smp = (sm >= 17'd32768) ? 16'sh8000 : -$signed(sm[15:0]);
		end
	end

	assign res.pop    = pop;
	assign res.valid  = v_s3;
	assign res.sample = smp;

endmodule

[rtl/rso_out.sv]
// ----------------------------------------------------------------------------
// Recursive sine oscillator output stage
// Buffers samples and emits each one as a left and a right item.
// ----------------------------------------------------------------------------
module rso_out (
	input  logic               clk,
	input  logic               arst_n,
	input  rso_pkg::result_t   res,
	output logic               room,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] sample,
	output logic               channel,
	output logic               last
);
	import rso_pkg::*;

	localparam int AW = $clog2(RSO_BUF_DEPTH);
	localparam int CW = $clog2(RSO_BUF_DEPTH + 1);

	logic signed [15:0] buf_q [RSO_BUF_DEPTH];
	logic [AW-1:0]      wr_q;
	logic [AW-1:0]      rd_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      rsv_q;
	logic               phase_q;
	logic               done;

	assign out_valid = (count_q != '0);
	assign sample    = buf_q[rd_q];
	assign channel   = phase_q;
	assign last      = phase_q;
	assign done      = out_valid && out_ready && phase_q;
	assign room      = (rsv_q < CW'(RSO_BUF_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
			rsv_q   <= '0;
			phase_q <= 1'b0;
		end else begin
			if (res.valid) begin
				wr_q <= wr_q + AW'(1);
			end
			if (out_valid && out_ready) begin
				phase_q <= !phase_q;
			end
			if (done) begin
				rd_q <= rd_q + AW'(1);
			end
			count_q <= count_q + CW'(res.valid) - CW'(done);
			rsv_q   <= rsv_q + CW'(res.pop) - CW'(done);
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			buf_q[wr_q] <= res.sample;
		end
	end

endmodule

[rtl/recursive_sine_oscillator.sv]
// ----------------------------------------------------------------------------
// Recursive sine oscillator
// Two-tap recursive sine generator with an APB register port.
// ----------------------------------------------------------------------------
// Each input item with sample_tick set advances the oscillator by one step;
// an item with sample_tick clear is taken and dropped. Every tick produces
// two result items carrying the same sample: the left slot (channel 0) and
// then the right slot (channel 1, last set).
// The left slot is presented once its tick has passed the input queue, the
// recursion loop and the scaling register into the output buffer; the right
// slot follows in the cycle after the left one is taken.
// Ticks do not overlap: the loop that multiplies the current value by the
// coefficient and subtracts the previous one finishes before the next tick
// can start.
// Up to two ticks wait in the input queue and up to four samples in the
// output buffer, so a stalled receiver first fills the buffer and then
// holds in_ready low; nothing is lost. Reset loads the register defaults
// and the start state, with no clearing pass. Registers must be written by
// the user through APB only while the block is idle; it does not enforce this.
module recursive_sine_oscillator #(
	parameter int VALUE_WIDTH = rso_pkg::RSO_VALUE_WIDTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               sample_tick,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] sample,
	output logic               channel,
	output logic               last
);
	import rso_pkg::*;

`include "recursive_sine_oscillator_defines.svh"

	logic signed [31:0] coeff_a_q;
	logic signed [31:0] start_value_q;
	logic [15:0]        period_q;
	reg_idx_t           idx;
	logic               tick_avail;
	logic               room;
	result_t            res;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coeff_a_q     <= RSO_COEFF_RESET;
			start_value_q <= RSO_START_RESET;
			period_q      <= RSO_PERIOD_RESET;
		end else if (psel && penable && pwrite && pready) begin
			unique case (idx)
				REG_COEFF_A:     coeff_a_q <= pwdata;
				REG_START_VALUE: start_value_q <= pwdata;
				REG_PERIOD:      period_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_COEFF_A:     prdata = coeff_a_q;
			REG_START_VALUE: prdata = start_value_q;
			REG_PERIOD:      prdata = {16'd0, period_q};
			default:         prdata = '0;
		endcase
	end

	rso_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample_tick(sample_tick),
		.pop        (res.pop),
		.tick_avail (tick_avail)
	);

	rso_core #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.coeff_a    (coeff_a_q),
		.start_value(start_value_q),
		.period     (period_q),
		.tick_avail (tick_avail),
		.room       (room),
		.res        (res)
	);

	rso_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.res      (res),
		.room     (room),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sample   (sample),
		.channel  (channel),
		.last     (last)
	);

	`RSO_ASSERT(a_right_follows_left, out_valid && out_ready && !last |=> last && $stable(sample))
	`RSO_ASSERT(a_pop_spacing, res.pop |=> !res.pop)
	`RSO_ASSERT_NEVER(a_full_queue_idle, !in_ready && !tick_avail)

endmodule

[test/recursive_sine_oscillator_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Recursive sine oscillator checker
// Watches the register port and both item channels, keeps its own copy of the
// oscillator state, and compares every result item with the predicted sample.
// ----------------------------------------------------------------------------
module recursive_sine_oscillator_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	input  logic               pready,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic               sample_tick,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [15:0] sample,
	input  logic               channel,
	input  logic               last,
	output int                 mismatches,
	output int                 outstanding,
	output int                 results_checked
);
	import rso_pkg::*;

	localparam int VALUE_FRAC = RSO_VALUE_WIDTH - 2;
	localparam longint VALUE_MAX = 64'sd2147483647;
	localparam longint VALUE_MIN = -64'sd2147483648;
	localparam int REPORT_LIMIT = 40;

	typedef struct packed {
		logic signed [15:0] sample;
		logic               channel;
		logic               last;
	} slot_t;

	slot_t expected_slots[$];
	slot_t want;

	logic signed [31:0] coeff_q;
	logic signed [31:0] start_q;
	logic [15:0]        period_q;
	logic signed [31:0] prev_q;
	logic signed [31:0] curr_q;
	logic signed [31:0] level;
	logic [15:0]        tick_count;
	logic signed [15:0] smp;
	int                 errors;
	int                 checked;

	// Coefficient product truncated toward zero, less the older value, saturated.
	function automatic logic signed [31:0] next_value(input logic signed [31:0] coeff,
			input logic signed [31:0] cur, input logic signed [31:0] prv);
		longint c;
		longint v;
		longint q;
		logic [63:0] prod;
		c = coeff;
		v = cur;
		prod = 64'(c < 0 ? -c : c) * 64'(v < 0 ? -v : v);
		q = longint'(prod >> RSO_COEFF_FRAC);
		if ((c < 0) != (v < 0))
			q = -q;
		q = q - longint'(prv);
		if (q > VALUE_MAX)
			q = VALUE_MAX;
		if (q < VALUE_MIN)
			q = VALUE_MIN;
		return q[31:0];
	endfunction

	function automatic logic signed [15:0] sample_of(input logic signed [31:0] v);
		longint x;
		logic [63:0] m;
		x = v;
		m = (64'(x < 0 ? -x : x) * RSO_SAMPLE_SCALE) >> VALUE_FRAC;
		if (x >= 0)
			return (m > 64'd32767) ? 16'sd32767 : m[15:0];
		return (m > 64'd32768) ? 16'sh8000 : -m[15:0];
	endfunction

	task automatic report_mismatch(input string msg);
		errors++;
		if (errors <= REPORT_LIMIT)
			$display("%0t ns: mismatch: %s", $time, msg);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coeff_q = RSO_COEFF_RESET;
			start_q = RSO_START_RESET;
			period_q = RSO_PERIOD_RESET;
			prev_q = '0;
			curr_q = RSO_START_RESET;
			tick_count = '0;
			expected_slots.delete();
			errors = 0;
			checked = 0;
			mismatches <= 0;
			outstanding <= 0;
			results_checked <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_COEFF_A:     coeff_q = pwdata;
					REG_START_VALUE: start_q = pwdata;
					REG_PERIOD:      period_q = pwdata[15:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (expected_slots.size() == 0) begin
					report_mismatch($sformatf("result with none expected: sample %0d channel %0b",
						sample, channel));
				end else begin
					want = expected_slots.pop_front();
					checked++;
					if (sample !== want.sample)
						report_mismatch($sformatf("sample %0d, expected %0d", sample, want.sample));
					if (channel !== want.channel)
						report_mismatch($sformatf("channel %b, expected %b", channel, want.channel));
					if (last !== want.last)
						report_mismatch($sformatf("last %b, expected %b", last, want.last));
				end
			end
			if (in_valid && in_ready && sample_tick === 1'b1) begin
				level = next_value(coeff_q, curr_q, prev_q);
				prev_q = curr_q;
				curr_q = level;
				smp = sample_of(level);
				tick_count = tick_count + 16'd1;
				if (tick_count == period_q) begin
					prev_q = '0;
					curr_q = start_q;
					tick_count = '0;
				end
				expected_slots.push_back('{smp, 1'b0, 1'b0});
				expected_slots.push_back('{smp, 1'b1, 1'b1});
			end
			mismatches <= errors;
			outstanding <= expected_slots.size();
			results_checked <= checked;
		end
	end

endmodule

[test/recursive_sine_oscillator_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Recursive sine oscillator testbench
// Drives ticks and register writes into the oscillator, with random gaps on
// the input side and random stalls on the output side, and takes the verdict
// from the checker that predicts every left and right sample.
// ----------------------------------------------------------------------------
module recursive_sine_oscillator_tb;
	import rso_pkg::*;

	localparam int LIMIT_CYCLES = 2000000;
	localparam int SETTLE_CYCLES = 12;
	localparam int RANDOM_PHASES = 9;
	localparam int TICKS_PER_PHASE = 75;
	localparam logic [3:0] UNMAPPED_ADDR = 4'd12;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [3:0]         paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	logic               in_valid;
	logic               in_ready;
	logic               sample_tick;
	logic               out_valid;
	logic               out_ready;
	logic signed [15:0] sample;
	logic               channel;
	logic               last;

	int mismatches;
	int outstanding;
	int results_checked;
	int ticks_sent;
	int drops_sent;
	int reg_writes;
	bit sender_gaps;
	bit sink_stalls;
	logic [15:0] tick_pos;
	logic [15:0] cur_per;

	recursive_sine_oscillator uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample_tick(sample_tick),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.sample     (sample),
		.channel    (channel),
		.last       (last)
	);

	recursive_sine_oscillator_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.pready         (pready),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.sample_tick    (sample_tick),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.sample         (sample),
		.channel        (channel),
		.last           (last),
		.mismatches     (mismatches),
		.outstanding    (outstanding),
		.results_checked(results_checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic int gap_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	function automatic logic [3:0] reg_addr(input reg_idx_t idx);
		return {idx, 2'b00};
	endfunction

	// The receiver alternates between ready runs and stalls while stalls are on.
	initial begin
		int hold;
		hold = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!sink_stalls) begin
				out_ready <= 1'b1;
			end else if (hold > 0) begin
				hold--;
			end else if (out_ready) begin
				out_ready <= 1'b0;
				hold = gap_length();
			end else begin
				out_ready <= 1'b1;
				hold = $urandom_range(0, 15);
			end
		end
	end

	task automatic write_register(input logic [3:0] addr, input logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		reg_writes++;
	endtask

	task automatic set_period(input logic [15:0] per);
		write_register(reg_addr(REG_PERIOD), {16'd0, per});
		cur_per = per;
	endtask

	task automatic send_item(input logic tick_bit);
		int gap;
		gap = sender_gaps ? gap_length() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample_tick <= tick_bit;
		do @(posedge clk); while (!in_ready);
		if (tick_bit) begin
			ticks_sent++;
			tick_pos = tick_pos + 16'd1;
			if (tick_pos == cur_per)
				tick_pos = '0;
		end else begin
			drops_sent++;
		end
	endtask

	// Holds the sender off until every predicted result has been taken.
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// A period one above the current count restarts the oscillator on the
	// next tick, so every setting starts from its own start value.
	task automatic run_setting(input logic [31:0] coeff, input logic [31:0] start,
			input logic [15:0] per, input int ticks, input int drop_pct);
		int n;
		write_register(reg_addr(REG_COEFF_A), coeff);
		write_register(reg_addr(REG_START_VALUE), start);
		set_period(tick_pos + 16'd1);
		send_item(1'b1);
		drain_results();
		set_period(per);
		n = 0;
		while (n < ticks) begin
			if ($urandom_range(1, 100) <= drop_pct) begin
				send_item(1'b0);
			end else begin
				send_item(1'b1);
				n++;
			end
		end
		drain_results();
	endtask

	initial begin
		logic [31:0] coeff;
		logic [31:0] start;
		logic [15:0] per;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_valid <= 1'b0;
		sample_tick <= 1'b0;
		sender_gaps = 1'b0;
		sink_stalls = 1'b0;
		ticks_sent = 0;
		drops_sent = 0;
		reg_writes = 0;
		tick_pos = '0;
		cur_per = RSO_PERIOD_RESET;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		send_item(1'b0);
		repeat (4) send_item(1'b1);
		send_item(1'b0);
		send_item(1'b1);
		drain_results();

		run_setting(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'd3, 3, 0);
		run_setting(32'h8000_0000, 32'h7FFF_FFFF, 16'd2, 2, 0);
		run_setting(32'h8000_0000, 32'h8000_0000, 16'd2, 2, 0);
		write_register(UNMAPPED_ADDR, 32'hFFFF_FFFF);
		run_setting(32'h0000_0000, 32'h0000_0000, 16'hFFFF, 3, 0);

		// Leave the counter at 50, then drop the period below it; the counter
		// has to run past the new period without restarting.
		run_setting(RSO_COEFF_RESET, RSO_START_RESET, 16'd1, 1, 0);
		run_setting(RSO_COEFF_RESET, RSO_START_RESET, 16'd100, 50, 0);
		set_period(16'd20);
		repeat (40) send_item(1'b1);
		drain_results();

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			sender_gaps = (phase != 3);
			sink_stalls = (phase != 3 && phase != 6);
			case ($urandom_range(0, 3))
				0: coeff = $urandom;
				1: coeff = $urandom_range(32'h7000_0000, 32'h7FFF_FFFF);
				2: coeff = $urandom_range(32'h0000_0000, 32'h7FFF_FFFF);
				default: coeff = -$urandom_range(32'h4000_0000, 32'h8000_0000);
			endcase
			start = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h2000_0000);
			case ($urandom_range(0, 9))
				0: per = 16'd0;
				1: per = 16'($urandom_range(1, 65535));
				2: per = 16'd1;
				default: per = 16'($urandom_range(2, 40));
			endcase
			if (phase == 4)
				write_register(UNMAPPED_ADDR, $urandom);
			run_setting(coeff, start, per, TICKS_PER_PHASE, 10);
		end

		$display("Checked %0d results from %0d ticks, %0d dropped items, %0d register writes.",
			results_checked, ticks_sent, drops_sent, reg_writes);
		$display("Covered reset defaults, saturating extremes, restarts, a period lowered below the count and random settings.");
		if (mismatches == 0 && outstanding == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

[sim.f]
+incdir+rtl
rtl/rso_pkg.sv
rtl/rso_front.sv
rtl/rso_core.sv
rtl/rso_out.sv
rtl/recursive_sine_oscillator.sv
test/recursive_sine_oscillator_checker.sv
test/recursive_sine_oscillator_tb.sv
